/* hdl/prx_pkg.sv */
// Shared types and constants for the printable run extractor.
package prx_pkg;

    localparam int unsigned RUN_W = 6;

    localparam logic [7:0] PRINT_LOW     = 8'h20;
    localparam logic [7:0] PRINT_HIGH    = 8'h7E;
    localparam logic [5:0] MIN_LEN_RESET = 6'd4;

    // Register indexes of the configuration port
    localparam logic REG_MIN_LENGTH = 1'b0;

    // Source of the next output transaction
    typedef enum logic [1:0] {
        OSEL_IN   = 2'd0,
        OSEL_HELD = 2'd1,
        OSEL_CUR  = 2'd2,
        OSEL_TERM = 2'd3
    } t_out_sel;

    typedef struct packed {
        logic     in_ready;
        logic     accept;
        logic     store;
        logic     burst_start;
        logic     burst_step;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_prx_cmd;

    typedef struct packed {
        logic printable;
        logic hit;
        logic flush;
        logic run_zero;
        logic in_eod;
        logic eod_held;
        logic burst_done;
        logic out_free;
    } t_prx_status;

endpackage

/* hdl/prx_ctrl.sv */
// Sequencer for the printable run extractor: accept, held-byte burst, terminator.
module prx_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  prx_pkg::t_prx_status i_status,
    output prx_pkg::t_prx_cmd    o_cmd
);
    import prx_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BURST = 4'b0010,
        ST_CUR   = 4'b0100,
        ST_TERM  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{default: '0, out_sel: OSEL_IN};
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_status.out_free;
                o_cmd.accept   = i_in_valid && i_status.out_free;
                if (o_cmd.accept) begin
                    if (i_status.printable) begin
                        if (i_status.hit || (i_status.flush && i_status.run_zero)) begin
                            // pass the byte straight out
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = OSEL_IN;
                            o_cmd.out_last = !i_status.in_eod;
                            if (i_status.in_eod) begin
                                n_state = ST_TERM;
                            end
                        end else if (!i_status.flush) begin
                            o_cmd.store = 1'b1;
                        end else begin
                            o_cmd.burst_start = 1'b1;
                            n_state           = ST_BURST;
                        end
                    end else if (i_status.hit) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OSEL_TERM;
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            ST_BURST: begin
                if (i_status.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = OSEL_HELD;
                    o_cmd.burst_step = 1'b1;
                    if (i_status.burst_done) begin
                        n_state = ST_CUR;
                    end
                end
            end
            ST_CUR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_CUR;
                    o_cmd.out_last = !i_status.eod_held;
                    n_state        = i_status.eod_held ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_TERM;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/prx_dp.sv */
// Datapath: run counter, held-byte memory, min_length register, output register.
module prx_dp #(
    parameter int unsigned MAX_MIN_LENGTH = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  logic                 i_eod,
    input  logic                 i_out_ready,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_value,
    input  prx_pkg::t_prx_cmd    i_cmd,
    output prx_pkg::t_prx_status o_status,
    output logic [5:0]           o_min_length,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_out_term,
    output logic                 o_out_last
);
    import prx_pkg::*;

    localparam int unsigned AW       = $clog2(MAX_MIN_LENGTH);
    localparam logic [5:0]  MAX_LEN  = 6'(MAX_MIN_LENGTH);
    localparam logic [5:0]  MIN_RST  = (MIN_LEN_RESET > MAX_LEN) ? MAX_LEN : MIN_LEN_RESET;

    logic [7:0]       mem [MAX_MIN_LENGTH];
    logic [7:0]       r_rd;
    logic [AW-1:0]    r_idx;
    logic [RUN_W-1:0] r_len;
    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run;
    logic [5:0]       r_min;
    logic [5:0]       n_min;
    logic [7:0]       r_byte;
    logic             r_eod;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_term;
    logic             r_out_last;
    logic             printable;
    logic             hit;
    logic             flush;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign printable = (i_byte >= PRINT_LOW) && (i_byte <= PRINT_HIGH);
    assign hit       = r_run >= r_min;
    assign flush     = ({1'b0, r_run} + 7'd1) >= {1'b0, r_min};

    assign o_status.printable  = printable;
    assign o_status.hit        = hit;
    assign o_status.flush      = flush;
    assign o_status.run_zero   = (r_run == '0);
    assign o_status.in_eod     = i_eod;
    assign o_status.eod_held   = r_eod;
    assign o_status.burst_done = ((6'(r_idx) + 6'd1) == r_len);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // clamp written minimum into 1..MAX
    always_comb begin
        n_min = i_cfg_value;
        if (n_min == 6'd0) begin
            n_min = 6'd1;
        end
        if (n_min > MAX_LEN) begin
            n_min = MAX_LEN;
        end
    end

    always_comb begin
        n_run = r_run;
        if (i_cmd.accept && printable && !hit) begin
            n_run = flush ? r_min : r_run + 6'd1;
        end
        if (i_cmd.accept && (!printable || i_eod)) begin
            n_run = '0;
        end
        if (i_cfg_we) begin
            n_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_min <= MIN_RST;
        end else begin
            r_run <= n_run;
            if (i_cfg_we) begin
                r_min <= n_min;
            end
        end
    end

    // input transaction fields kept for the burst tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_byte;
            r_eod  <= i_eod;
        end
        if (i_cmd.burst_start) begin
            r_len <= r_run;
            r_idx <= '0;
        end else if (i_cmd.burst_step) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    assign rd_en   = i_cmd.burst_start || i_cmd.burst_step;
    assign rd_addr = i_cmd.burst_start ? '0 : r_idx + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_run[AW-1:0]] <= i_byte;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_term <= (i_cmd.out_sel == OSEL_TERM);
            r_out_last <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OSEL_IN:   r_out_char <= i_byte;
                OSEL_HELD: r_out_char <= r_rd;
                OSEL_CUR:  r_out_char <= r_byte;
                OSEL_TERM: r_out_char <= 8'h00;
                default:   r_out_char <= 8'h00;
            endcase
        end
    end

    assign o_min_length = r_min;
    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_term   = r_out_term;
    assign o_out_last   = r_out_last;

endmodule

/* hdl/printable_run_extractor.sv */
// Top level of the printable run extractor: stream ports, APB register, ctrl + datapath.
//
// Usage:
//   Slave stream: one raw byte per transaction (s_axis_tdata), s_axis_tlast on
//   the last byte of the data. Master stream: one string byte per transaction
//   (m_axis_tdata); m_axis_tuser marks a terminator (tdata zero), m_axis_tlast
//   the last transaction that an input byte causes.
//   min_length sits at APB byte address 0 (6 bits, reset 4, a write of 0 stores
//   1, writes above MAX_MIN_LENGTH saturate). A write to min_length clears the run
//   counter; write only while the stream is idle.
// Flow and throughput:
//   A passed byte, or a terminator closing a run, shows on the master side in the
//   cycle after acceptance; one byte per cycle is sustained while the output
//   register is free. Held-only bytes are accepted and produce nothing. The byte
//   that makes a run reach min_length reads the held-byte memory in its accept
//   cycle, then the single read port streams the N held bytes and then the byte
//   itself while input pauses; end of data on a reported run adds a terminator.
// Reset: synchronous, active low; output register empties, run counter clears,
//   min_length returns to 4. Held-byte memory is not cleared.
// Backpressure: the output register parts the sides; the next input is taken in
//   the same cycle the waiting result is taken, and input stalls while it is full.
module printable_run_extractor #(
    parameter int unsigned MAX_MIN_LENGTH = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tuser,   // [0] terminator
    output logic        m_axis_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import prx_pkg::*;

    t_prx_cmd    cmd;
    t_prx_status status;
    logic        cfg_we;
    logic [5:0]  min_length;

    // APB: always ready, write lands in the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MIN_LENGTH);
    assign prdata = (paddr[2] == REG_MIN_LENGTH) ? {26'd0, min_length} : 32'd0;

    assign s_axis_tready = cmd.in_ready;

    prx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prx_dp #(
        .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (s_axis_tdata),
        .i_eod        (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_value  (pwdata[5:0]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_min_length (min_length),
        .o_out_valid  (m_axis_tvalid),
        .o_out_char   (m_axis_tdata),
        .o_out_term   (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

/* hdl/prx_checker.sv */
// Port-level assertions for the printable run extractor, bound to the top level.
module prx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);
    import prx_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("terminator carries a character");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("terminator not last result");

    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata >= PRINT_LOW
            && m_axis_tdata <= PRINT_HIGH)
        else $error("non-printable character emitted");

endmodule

bind printable_run_extractor prx_checker u_prx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
